FILE: rtl/pidc_pkg.sv
// Shared types and constants for the clamped PID controller.
// No dependencies; imported by pidc_clamp and pid_controller_clamped.
`timescale 1ns / 1ps

package pidc_pkg;

    localparam int unsigned VAL_W  = 32;   // Q16.16 sample and gain width
    localparam int unsigned ERR_W  = 33;   // difference of two samples
    localparam int unsigned PROD_W = 65;   // ERR_W x VAL_W product
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned TERM_W = PROD_W - FRAC_W;   // product after >> 16
    localparam int unsigned OUT_W  = 26;   // clamped drive / integral
    localparam int unsigned SUM_W  = 51;   // exact sum of three terms
    localparam int unsigned IDX_W  = 2;

    localparam logic signed [OUT_W-1:0] LIMIT_Q16  = 26'sd26214400;   // 400.0
    localparam logic signed [SUM_W-1:0] LIMIT_WIDE = 51'sd26214400;

    typedef enum logic [0:0] {
        ACT_SAMPLE = 1'b0,
        ACT_CLEAR  = 1'b1
    } pidc_action_t;

    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_DERIV_GAIN = 2'd2,
        REG_NONE       = 2'd3
    } pidc_reg_idx_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    hit;
    } pidc_clamp_t;

endpackage

FILE: rtl/pidc_clamp.sv
// Limits a wide exact sum to +-400.0 (Q16.16) and flags the clamp.
// Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_clamp
    import pidc_pkg::*;
(
    input  logic signed [SUM_W-1:0] sum_in,
    output pidc_clamp_t             res
);

    // exactly at the limit is not a clamp
    always_comb begin
        priority if (sum_in > LIMIT_WIDE) begin
            res.value = LIMIT_Q16;
            res.hit   = 1'b1;
        end else if (sum_in < -LIMIT_WIDE) begin
            res.value = -LIMIT_Q16;
            res.hit   = 1'b1;
        end else begin
            res.value = sum_in[OUT_W-1:0];
            res.hit   = 1'b0;
        end
    end

endmodule

FILE: rtl/pid_controller_clamped.sv
// Clamped PID controller top level: input register, product stage, result stage.
// Depends on pidc_pkg and pidc_clamp.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  cfg      | cfg_wr_en               | cfg_index[1:0], cfg_data[31:0]
//  s_       | s_valid / s_ready       | s_action, s_measured, s_target
//  m_       | m_valid / m_ready       | m_drive[25:0], m_drive_saturated
//
// One word in and one word out per cycle unless m_ready stalls the pipe.
// The three 33x32 multiplies sit between the input and product registers; the integral
// update and both clamps sit between the product and result registers.
// Each stage holds its word while the one after is full and blocked; bubbles close up.
// aresetn (synchronous) empties the pipe and zeroes gains, integral and last measurement.
`timescale 1ns / 1ps

module pid_controller_clamped
    import pidc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [VAL_W-1:0]        cfg_data,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  logic signed [VAL_W-1:0] s_measured,
    input  logic signed [VAL_W-1:0] s_target,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_drive,
    output logic                    m_drive_saturated
);

    // gains
    logic signed [VAL_W-1:0]  prop_gain_reg;
    logic signed [VAL_W-1:0]  integ_gain_reg;
    logic signed [VAL_W-1:0]  deriv_gain_reg;

    // controller state
    logic signed [OUT_W-1:0]  integ_reg;
    logic signed [VAL_W-1:0]  prev_meas_reg;

    // stage 1: input register
    logic                     s1_valid_reg;
    pidc_action_t             s1_action_reg;
    logic signed [VAL_W-1:0]  s1_meas_reg;
    logic signed [VAL_W-1:0]  s1_tgt_reg;

    // stage 2: products
    logic                     s2_valid_reg;
    pidc_action_t             s2_action_reg;
    logic signed [PROD_W-1:0] p_prod_reg;
    logic signed [PROD_W-1:0] i_prod_reg;
    logic signed [PROD_W-1:0] d_prod_reg;

    // stage 3: result
    logic                     s3_valid_reg;
    logic signed [OUT_W-1:0]  drive_reg;
    logic                     sat_reg;

    logic                     rdy2;
    logic                     rdy3;
    logic                     adv1;
    logic                     adv2;
    logic                     s_acc;

    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W-1:0]  diff;
    logic signed [PROD_W-1:0] p_prod_next;
    logic signed [PROD_W-1:0] i_prod_next;
    logic signed [PROD_W-1:0] d_prod_next;

    logic signed [SUM_W-1:0]  integ_sum;
    logic signed [SUM_W-1:0]  drive_sum;
    pidc_clamp_t              integ_clamp;
    pidc_clamp_t              drive_clamp;
    logic signed [OUT_W-1:0]  integ_next;

    // handshake chain
    assign rdy3    = !s3_valid_reg || m_ready;
    assign rdy2    = !s2_valid_reg || rdy3;
    assign s_ready = !s1_valid_reg || rdy2;
    assign adv1    = s1_valid_reg && rdy2;
    assign adv2    = s2_valid_reg && rdy3;
    assign s_acc   = s_valid && s_ready;

    // stage 1 -> 2: differences and products
    assign err  = ERR_W'(s1_tgt_reg) - ERR_W'(s1_meas_reg);
    assign diff = ERR_W'(s1_meas_reg) - ERR_W'(prev_meas_reg);
    assign p_prod_next = err * prop_gain_reg;
    assign i_prod_next = err * integ_gain_reg;
    assign d_prod_next = diff * deriv_gain_reg;

    // stage 2 -> 3: floor shift by 16, integral, drive
    assign integ_sum = SUM_W'(integ_reg) + SUM_W'($signed(i_prod_reg[PROD_W-1:FRAC_W]));

    pidc_clamp u_integ_clamp (
        .sum_in (integ_sum),
        .res    (integ_clamp)
    );

    assign integ_next = integ_clamp.value;
    assign drive_sum  = SUM_W'($signed(p_prod_reg[PROD_W-1:FRAC_W]))
                      + SUM_W'(integ_next)
                      - SUM_W'($signed(d_prod_reg[PROD_W-1:FRAC_W]));

    pidc_clamp u_drive_clamp (
        .sum_in (drive_sum),
        .res    (drive_clamp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (pidc_reg_idx_t'(cfg_index))
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            integ_reg     <= '0;
            prev_meas_reg <= '0;
        end else begin
            s1_valid_reg <= s_acc || (s1_valid_reg && !adv1);
            s2_valid_reg <= adv1 || (s2_valid_reg && !adv2);
            s3_valid_reg <= adv2 || (s3_valid_reg && !m_ready);
            // last measurement moves with the word leaving stage 1
            if (adv1) begin
                prev_meas_reg <= (s1_action_reg == ACT_CLEAR) ? '0 : s1_meas_reg;
            end
            if (adv2) begin
                integ_reg <= (s2_action_reg == ACT_CLEAR) ? '0 : integ_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_action_reg <= pidc_action_t'(s_action);
            s1_meas_reg   <= s_measured;
            s1_tgt_reg    <= s_target;
        end
        if (adv1) begin
            s2_action_reg <= s1_action_reg;
            p_prod_reg    <= p_prod_next;
            i_prod_reg    <= i_prod_next;
            d_prod_reg    <= d_prod_next;
        end
        if (adv2) begin
            if (s2_action_reg == ACT_CLEAR) begin
                drive_reg <= '0;
                sat_reg   <= 1'b0;
            end else begin
                drive_reg <= drive_clamp.value;
                sat_reg   <= drive_clamp.hit;
            end
        end
    end

    assign m_valid           = s3_valid_reg;
    assign m_drive           = drive_reg;
    assign m_drive_saturated = sat_reg;

`ifndef SYNTHESIS
    a_integ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (integ_reg <= LIMIT_Q16) && (integ_reg >= -LIMIT_Q16))
        else $error("integral outside +-400");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drive_saturated) |-> (m_drive == LIMIT_Q16 || m_drive == -LIMIT_Q16))
        else $error("saturated flag without drive at a limit");

    a_clear_integ: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv2 && s2_action_reg == ACT_CLEAR) |=> (integ_reg == '0))
        else $error("clear did not zero the integral");

    a_clear_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv1 && s1_action_reg == ACT_CLEAR) |=> (prev_meas_reg == '0))
        else $error("clear did not zero the last measurement");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && !m_ready))
        else $error("input stalled while the pipe has room");
`endif

endmodule
